>>> hdl/ndif_pkg.sv
package ndif_pkg;

   // Default sizes
   localparam int PIT_ENTRIES_DEF     = 16;
   localparam int FACES_PER_ENTRY_DEF = 8;
   localparam int CACHE_ENTRIES_DEF   = 8;
   localparam int LOCAL_ENTRIES_DEF   = 8;
   localparam int PORTS_DEF           = 8;
   localparam int NAME_BITS_DEF       = 64;

   localparam logic [3:0] USER_PORT = 4'd8;

   // Commands
   localparam logic [2:0] CMD_INTEREST = 3'd0;
   localparam logic [2:0] CMD_OBJECT   = 3'd1;
   localparam logic [2:0] CMD_NOOBJECT = 3'd2;
   localparam logic [2:0] CMD_RETRIEVE = 3'd3;
   localparam logic [2:0] CMD_CREATE   = 3'd4;
   localparam logic [2:0] CMD_DELETE   = 3'd5;

   // Actions
   localparam logic [2:0] ACT_STATUS    = 3'd0;
   localparam logic [2:0] ACT_INTEREST  = 3'd1;
   localparam logic [2:0] ACT_OBJECT    = 3'd2;
   localparam logic [2:0] ACT_NOOBJECT  = 3'd3;
   localparam logic [2:0] ACT_DELIVER   = 3'd4;
   localparam logic [2:0] ACT_USER_NF   = 3'd5;

   // Status codes
   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_LOCAL     = 4'd1;
   localparam logic [3:0] ST_CACHE     = 4'd2;
   localparam logic [3:0] ST_FULL      = 4'd3;
   localparam logic [3:0] ST_ID_USED   = 4'd4;
   localparam logic [3:0] ST_NO_NET    = 4'd5;
   localparam logic [3:0] ST_NO_MATCH  = 4'd6;
   localparam logic [3:0] ST_DUPLICATE = 4'd7;
   localparam logic [3:0] ST_STORE_FUL = 4'd8;
   localparam logic [3:0] ST_NOT_FOUND = 4'd9;

   // Face states
   localparam logic [1:0] FS_NONE   = 2'd0;
   localparam logic [1:0] FS_RESP   = 2'd1;
   localparam logic [1:0] FS_WAIT   = 2'd2;
   localparam logic [1:0] FS_CLOSED = 2'd3;

   // Register indexes
   localparam logic CSR_NEIGHBOR = 1'b0;
   localparam logic CSR_NETWORK  = 1'b1;

   typedef struct packed {
      logic [2:0]  command;
      logic [2:0]  arrival_port;
      logic [7:0]  search_id;
      logic [63:0] name_key;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  out_port;
      logic [7:0]  out_id;
      logic [63:0] out_name;
      logic [3:0]  status;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOC_SCAN,
      S_LOC_DONE,
      S_CACHE_SCAN,
      S_CACHE_DONE,
      S_PIT_SCAN,
      S_PIT_DONE,
      S_FACE_SCAN,
      S_FACE_DONE,
      S_FWD,
      S_RESULT
   } seq_state_type;

endpackage

>>> hdl/ndif_ram.sv
module ndif_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> hdl/named_data_interest_forwarder_unit.sv
// Most commands scan, by their kind, some or all of the local store, the cache, the pending
// table and the faces of one entry through their RAMs, one entry a cycle.
// Throughput: one command at a time; the next is taken once the last result is queued.
// Forwarded interests leave one a cycle, paced by the result register.
// Reset (synchronous): clears all valid bits, face counts, the access clock and config.
module named_data_interest_forwarder_unit #(
   parameter int PIT_ENTRIES     = ndif_pkg::PIT_ENTRIES_DEF,
   parameter int FACES_PER_ENTRY = ndif_pkg::FACES_PER_ENTRY_DEF,
   parameter int CACHE_ENTRIES   = ndif_pkg::CACHE_ENTRIES_DEF,
   parameter int LOCAL_ENTRIES   = ndif_pkg::LOCAL_ENTRIES_DEF,
   parameter int PORTS           = ndif_pkg::PORTS_DEF,
   parameter int NAME_BITS       = ndif_pkg::NAME_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ndif_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ndif_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata
);

   import ndif_pkg::*;

   localparam int NB   = NAME_BITS;
   localparam int LAW  = (LOCAL_ENTRIES > 1) ? $clog2(LOCAL_ENTRIES) : 1;
   localparam int CAW  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int PAW  = $clog2(PIT_ENTRIES);
   localparam int FDEP = PIT_ENTRIES * FACES_PER_ENTRY;
   localparam int FMW  = $clog2(FDEP);
   localparam int FCW  = $clog2(FACES_PER_ENTRY + 1);
   localparam int M1   = (LOCAL_ENTRIES > CACHE_ENTRIES) ? LOCAL_ENTRIES : CACHE_ENTRIES;
   localparam int M2   = (PIT_ENTRIES > FACES_PER_ENTRY) ? PIT_ENTRIES : FACES_PER_ENTRY;
   localparam int SMAX = (M1 > M2) ? M1 : M2;
   localparam int CNTW = $clog2(SMAX + 1);

   // Configuration
   logic [7:0] neighbor_ff;
   logic       network_ff;

   // Sequencer
   seq_state_type state_ff, state_in;

   // Current command
   logic [2:0]    cmd_ff;
   logic [2:0]    port_ff;
   logic [7:0]    id_ff;
   logic [NB-1:0] name_ff;

   // Valid bits and counters
   logic             local_valid_ff [LOCAL_ENTRIES];
   logic             cache_valid_ff [CACHE_ENTRIES];
   logic             pit_valid_ff   [PIT_ENTRIES];
   logic [FCW-1:0]   face_count_ff  [PIT_ENTRIES];
   logic [31:0]      clock_cnt_ff;

   // Scan control
   logic [CNTW-1:0] cnt_ff, idx_ff, scan_lim;
   logic            chk_ff, scan_go, scanning, scan_end;

   // Scan findings
   logic           l_hit_ff, l_free_ff;
   logic [LAW-1:0] l_hidx_ff, l_fidx_ff;
   logic           c_hit_ff, c_free_ff;
   logic [CAW-1:0] c_hidx_ff, c_fidx_ff, c_midx_ff;
   logic [31:0]    c_mstamp_ff;
   logic           p_hit_ff, p_idm_ff, p_free_ff;
   logic [PAW-1:0] p_hidx_ff, p_fidx_ff;
   logic           f_pm_ff, f_wait_ff, f_resp_ff;
   logic [FCW-1:0] f_pmidx_ff;
   logic [3:0]     f_rport_ff;

   // Entry being worked on and forwarding
   logic [PAW-1:0] e_ff;
   logic [7:0]     fwd_ff;
   logic [FCW-1:0] fcnt_ff;

   // Staged single result
   logic [2:0] res_act_ff;
   logic [3:0] res_port_ff;
   logic [3:0] res_stat_ff;

   // Output register
   logic    rsp_vld_ff;
   rsp_type rsp_ff;
   logic    slot_free;

   // RAM ports
   logic                lr_en, cr_en, pr_en, fr_en;
   logic [NB-1:0]       l_rd;
   logic [NB+31:0]      c_rd;
   logic [NB+7:0]       p_rd;
   logic [5:0]          f_rd;
   logic                lw_en, cw_en, pw_en, fw_en;
   logic [LAW-1:0]      lw_idx;
   logic [CAW-1:0]      cw_idx;
   logic [PAW-1:0]      pw_idx;
   logic [FMW-1:0]      fw_addr, fr_addr;
   logic [5:0]          fw_data;

   // Other control from the sequencer
   logic           lv_wr, lv_val;
   logic [LAW-1:0] lv_idx;
   logic           pv_wr, pv_val;
   logic [PAW-1:0] pv_idx;
   logic           fc_wr;
   logic [PAW-1:0] fc_idx;
   logic [FCW-1:0] fc_val;
   logic           e_load;
   logic [PAW-1:0] e_in;
   logic           fwd_load;
   logic [7:0]     fwd_in;
   logic           fwd_step;
   logic           res_go;
   logic [2:0]     res_act_in;
   logic [3:0]     res_port_in;
   logic [3:0]     res_stat_in;
   logic           rsp_load;
   rsp_type        rsp_in;

   // Derived values
   logic [FCW-1:0] fcount_cur;
   logic [7:0]     fwd_port_mask, fwd_user_mask, fwd_rest;
   logic [2:0]     fwd_pick;
   logic           fwd_last;
   logic [CAW-1:0] c_ins_idx;

   function automatic logic [FMW-1:0] face_addr(logic [PAW-1:0] e, logic [FCW-1:0] i);
      return FMW'(FMW'(e) * FMW'(FACES_PER_ENTRY)) + FMW'(i);
   endfunction

   function automatic logic [7:0] fwd_mask(logic [7:0] nbr, logic [3:0] skip);
      logic [7:0] m;
      for (int i = 0; i < 8; i++) begin
         m[i] = nbr[i] && (i < PORTS) && (4'(i) != skip);
      end
      return m;
   endfunction

   // Memories
   ndif_ram #(.WIDTH(NB), .DEPTH(LOCAL_ENTRIES)) u_local_ram (
      .clock(clock), .wr_en(lw_en), .wr_addr(lw_idx), .wr_data(name_ff),
      .rd_en(lr_en), .rd_addr(cnt_ff[LAW-1:0]), .rd_data(l_rd));

   ndif_ram #(.WIDTH(NB + 32), .DEPTH(CACHE_ENTRIES)) u_cache_ram (
      .clock(clock), .wr_en(cw_en), .wr_addr(cw_idx),
      .wr_data({name_ff, clock_cnt_ff + 32'd1}),
      .rd_en(cr_en), .rd_addr(cnt_ff[CAW-1:0]), .rd_data(c_rd));

   ndif_ram #(.WIDTH(NB + 8), .DEPTH(PIT_ENTRIES)) u_pit_ram (
      .clock(clock), .wr_en(pw_en), .wr_addr(pw_idx), .wr_data({id_ff, name_ff}),
      .rd_en(pr_en), .rd_addr(cnt_ff[PAW-1:0]), .rd_data(p_rd));

   ndif_ram #(.WIDTH(6), .DEPTH(FDEP)) u_face_ram (
      .clock(clock), .wr_en(fw_en), .wr_addr(fw_addr), .wr_data(fw_data),
      .rd_en(fr_en), .rd_addr(fr_addr), .rd_data(f_rd));

   // Scan addressing
   assign fcount_cur = face_count_ff[e_ff];
   assign fr_addr    = face_addr(e_ff, FCW'(cnt_ff));
   assign scanning   = (state_ff == S_LOC_SCAN) || (state_ff == S_CACHE_SCAN) ||
                       (state_ff == S_PIT_SCAN) || (state_ff == S_FACE_SCAN);

   always_comb begin
      case (state_ff)
         S_LOC_SCAN:   scan_lim = CNTW'(LOCAL_ENTRIES);
         S_CACHE_SCAN: scan_lim = CNTW'(CACHE_ENTRIES);
         S_PIT_SCAN:   scan_lim = CNTW'(PIT_ENTRIES);
         default:      scan_lim = CNTW'(FACES_PER_ENTRY);
      endcase
   end

   assign scan_end = chk_ff && (idx_ff == scan_lim - CNTW'(1));
   assign lr_en = (state_ff == S_LOC_SCAN)   && (cnt_ff < scan_lim);
   assign cr_en = (state_ff == S_CACHE_SCAN) && (cnt_ff < scan_lim);
   assign pr_en = (state_ff == S_PIT_SCAN)   && (cnt_ff < scan_lim);
   assign fr_en = (state_ff == S_FACE_SCAN)  && (cnt_ff < scan_lim);

   // Forwarding helpers
   assign fwd_port_mask = fwd_mask(neighbor_ff, {1'b0, port_ff});
   assign fwd_user_mask = fwd_mask(neighbor_ff, USER_PORT);
   assign c_ins_idx     = c_free_ff ? c_fidx_ff : c_midx_ff;

   always_comb begin
      fwd_pick = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (fwd_ff[i]) begin
            fwd_pick = 3'(i);
         end
      end
   end

   assign fwd_rest  = fwd_ff & ~(8'd1 << fwd_pick);
   assign fwd_last  = (fwd_rest == 8'd0) ||
                      (fcnt_ff + FCW'(1) == FCW'(FACES_PER_ENTRY));
   assign slot_free = !rsp_vld_ff || !rsp_stall;

   // Next state and control
   always_comb begin
      state_in    = state_ff;
      scan_go     = 1'b0;
      lw_en = 1'b0; lw_idx = l_fidx_ff;
      cw_en = 1'b0; cw_idx = c_hidx_ff;
      pw_en = 1'b0; pw_idx = p_fidx_ff;
      fw_en = 1'b0; fw_addr = face_addr(e_ff, f_pmidx_ff); fw_data = {1'b0, port_ff, FS_RESP};
      lv_wr = 1'b0; lv_idx = l_hidx_ff; lv_val = 1'b0;
      pv_wr = 1'b0; pv_idx = e_ff; pv_val = 1'b0;
      fc_wr = 1'b0; fc_idx = e_ff; fc_val = fcount_cur;
      e_load = 1'b0; e_in = p_hidx_ff;
      fwd_load = 1'b0; fwd_in = fwd_port_mask;
      fwd_step = 1'b0;
      res_go = 1'b0; res_act_in = ACT_STATUS; res_port_in = 4'd0; res_stat_in = ST_OK;
      rsp_load = 1'b0;
      rsp_in = '{action: res_act_ff, out_port: res_port_ff, out_id: id_ff,
                 out_name: 64'(name_ff), status: res_stat_ff, last: 1'b1};

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // Decode the accepted transaction
               unique case (req_data.command)
                  CMD_INTEREST, CMD_CREATE, CMD_DELETE: begin
                     scan_go = 1'b1; state_in = S_LOC_SCAN;
                  end
                  CMD_RETRIEVE: begin
                     if (network_ff) begin
                        scan_go = 1'b1; state_in = S_LOC_SCAN;
                     end else begin
                        res_go = 1'b1; res_stat_in = ST_NO_NET; state_in = S_RESULT;
                     end
                  end
                  CMD_OBJECT, CMD_NOOBJECT: begin
                     scan_go = 1'b1; state_in = S_PIT_SCAN;
                  end
                  default: begin
                     res_go = 1'b1; state_in = S_RESULT;
                  end
               endcase
            end
         end

         S_LOC_SCAN:   if (scan_end) state_in = S_LOC_DONE;
         S_CACHE_SCAN: if (scan_end) state_in = S_CACHE_DONE;
         S_PIT_SCAN:   if (scan_end) state_in = S_PIT_DONE;
         S_FACE_SCAN:  if (scan_end) state_in = S_FACE_DONE;

         S_LOC_DONE: begin
            state_in = S_RESULT;
            res_go   = 1'b1;
            case (cmd_ff)
               CMD_INTEREST: begin
                  if (l_hit_ff) begin
                     res_act_in = ACT_OBJECT; res_port_in = {1'b0, port_ff};
                     res_stat_in = ST_LOCAL;
                  end else begin
                     res_go = 1'b0; scan_go = 1'b1; state_in = S_CACHE_SCAN;
                  end
               end
               CMD_RETRIEVE: begin
                  if (l_hit_ff) begin
                     res_stat_in = ST_LOCAL;
                  end else begin
                     res_go = 1'b0; scan_go = 1'b1; state_in = S_CACHE_SCAN;
                  end
               end
               CMD_CREATE: begin
                  if (l_hit_ff) begin
                     res_stat_in = ST_DUPLICATE;
                  end else if (l_free_ff) begin
                     lw_en = 1'b1; lv_wr = 1'b1; lv_idx = l_fidx_ff; lv_val = 1'b1;
                  end else begin
                     res_stat_in = ST_STORE_FUL;
                  end
               end
               default: begin
                  // Delete
                  if (l_hit_ff) begin
                     lv_wr = 1'b1;
                  end else begin
                     res_stat_in = ST_NOT_FOUND;
                  end
               end
            endcase
         end

         S_CACHE_DONE: begin
            if (c_hit_ff) begin
               cw_en = 1'b1;
            end
            case (cmd_ff)
               CMD_OBJECT: begin
                  if (!c_hit_ff) begin
                     cw_en = 1'b1; cw_idx = c_ins_idx;
                  end
                  scan_go = 1'b1; state_in = S_FACE_SCAN;
               end
               default: begin
                  if (c_hit_ff) begin
                     res_go = 1'b1; state_in = S_RESULT; res_stat_in = ST_CACHE;
                     if (cmd_ff == CMD_INTEREST) begin
                        res_act_in = ACT_OBJECT; res_port_in = {1'b0, port_ff};
                     end
                  end else begin
                     scan_go = 1'b1; state_in = S_PIT_SCAN;
                  end
               end
            endcase
         end

         S_PIT_DONE: begin
            case (cmd_ff)
               CMD_OBJECT, CMD_NOOBJECT: begin
                  if (!p_hit_ff) begin
                     res_go = 1'b1; res_stat_in = ST_NO_MATCH; state_in = S_RESULT;
                  end else begin
                     e_load = 1'b1; scan_go = 1'b1;
                     state_in = (cmd_ff == CMD_OBJECT) ? S_CACHE_SCAN : S_FACE_SCAN;
                  end
               end
               CMD_INTEREST: begin
                  if (p_hit_ff) begin
                     e_load = 1'b1; scan_go = 1'b1; state_in = S_FACE_SCAN;
                  end else if (!p_free_ff) begin
                     res_go = 1'b1; state_in = S_RESULT; res_stat_in = ST_FULL;
                     res_act_in = ACT_NOOBJECT; res_port_in = {1'b0, port_ff};
                  end else if (fwd_port_mask == 8'd0) begin
                     res_go = 1'b1; state_in = S_RESULT; res_stat_in = ST_NOT_FOUND;
                     res_act_in = ACT_NOOBJECT; res_port_in = {1'b0, port_ff};
                  end else begin
                     // Allocate the entry with the arrival port as response face
                     pw_en = 1'b1; pv_wr = 1'b1; pv_idx = p_fidx_ff; pv_val = 1'b1;
                     fw_en = 1'b1; fw_addr = face_addr(p_fidx_ff, FCW'(0));
                     fw_data = {1'b0, port_ff, FS_RESP};
                     fc_wr = 1'b1; fc_idx = p_fidx_ff; fc_val = FCW'(1);
                     e_load = 1'b1; e_in = p_fidx_ff;
                     fwd_load = 1'b1; fwd_in = fwd_port_mask;
                     state_in = S_FWD;
                  end
               end
               default: begin
                  // Retrieve
                  res_go = 1'b1; state_in = S_RESULT;
                  if (p_idm_ff) begin
                     res_stat_in = ST_ID_USED;
                  end else if (!p_free_ff) begin
                     res_stat_in = ST_FULL;
                  end else if (fwd_user_mask == 8'd0) begin
                     res_stat_in = ST_NOT_FOUND;
                  end else begin
                     res_go = 1'b0;
                     pw_en = 1'b1; pv_wr = 1'b1; pv_idx = p_fidx_ff; pv_val = 1'b1;
                     fw_en = 1'b1; fw_addr = face_addr(p_fidx_ff, FCW'(0));
                     fw_data = {USER_PORT, FS_RESP};
                     fc_wr = 1'b1; fc_idx = p_fidx_ff; fc_val = FCW'(1);
                     e_load = 1'b1; e_in = p_fidx_ff;
                     fwd_load = 1'b1; fwd_in = fwd_user_mask;
                     state_in = S_FWD;
                  end
               end
            endcase
         end

         S_FACE_DONE: begin
            res_go = 1'b1; state_in = S_RESULT;
            case (cmd_ff)
               CMD_INTEREST: begin
                  if (f_pm_ff) begin
                     fw_en = 1'b1;
                  end else if (fcount_cur < FCW'(FACES_PER_ENTRY)) begin
                     fw_en = 1'b1; fw_addr = face_addr(e_ff, fcount_cur);
                     fc_wr = 1'b1; fc_val = fcount_cur + FCW'(1);
                  end else begin
                     res_stat_in = ST_FULL;
                  end
               end
               CMD_OBJECT: begin
                  pv_wr = 1'b1;
                  if (f_resp_ff) begin
                     res_port_in = f_rport_ff;
                     res_act_in  = (f_rport_ff == USER_PORT) ? ACT_DELIVER : ACT_OBJECT;
                  end
               end
               default: begin
                  // Noobject: close the arrival face, answer once nobody waits
                  if (f_pm_ff) begin
                     fw_en = 1'b1; fw_data = {1'b0, port_ff, FS_CLOSED};
                  end
                  if (!f_wait_ff) begin
                     pv_wr = 1'b1;
                     if (f_resp_ff) begin
                        res_port_in = f_rport_ff;
                        res_act_in  = (f_rport_ff == USER_PORT) ? ACT_USER_NF : ACT_NOOBJECT;
                     end
                  end
               end
            endcase
         end

         S_FWD: begin
            if (slot_free) begin
               // Send one interest and record its waiting face
               fwd_step = 1'b1;
               fw_en = 1'b1; fw_addr = face_addr(e_ff, fcnt_ff);
               fw_data = {1'b0, fwd_pick, FS_WAIT};
               fc_wr = 1'b1; fc_val = fcnt_ff + FCW'(1);
               rsp_load = 1'b1;
               rsp_in = '{action: ACT_INTEREST, out_port: {1'b0, fwd_pick}, out_id: id_ff,
                          out_name: 64'(name_ff), status: ST_OK, last: fwd_last};
               if (fwd_last) begin
                  state_in = S_IDLE;
               end
            end
         end

         S_RESULT: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         neighbor_ff  <= 8'd0;
         network_ff   <= 1'b0;
         rsp_vld_ff   <= 1'b0;
         clock_cnt_ff <= 32'd0;
         for (int i = 0; i < LOCAL_ENTRIES; i++) local_valid_ff[i] <= 1'b0;
         for (int i = 0; i < CACHE_ENTRIES; i++) cache_valid_ff[i] <= 1'b0;
         for (int i = 0; i < PIT_ENTRIES; i++) begin
            pit_valid_ff[i]  <= 1'b0;
            face_count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            if (csr_index == CSR_NEIGHBOR) begin
               neighbor_ff <= csr_wdata;
            end else begin
               network_ff <= csr_wdata[0];
            end
         end
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
         if (cw_en) begin
            clock_cnt_ff           <= clock_cnt_ff + 32'd1;
            cache_valid_ff[cw_idx] <= 1'b1;
         end
         if (lv_wr) local_valid_ff[lv_idx] <= lv_val;
         if (pv_wr) pit_valid_ff[pv_idx]   <= pv_val;
         if (fc_wr) face_count_ff[fc_idx]  <= fc_val;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      // Capture the command, name masked to its width
      if (state_ff == S_IDLE && req_valid) begin
         cmd_ff  <= req_data.command;
         port_ff <= req_data.arrival_port;
         id_ff   <= req_data.search_id;
         name_ff <= req_data.name_key[NB-1:0];
      end
      if (rsp_load) rsp_ff <= rsp_in;
      if (res_go) begin
         res_act_ff  <= res_act_in;
         res_port_ff <= res_port_in;
         res_stat_ff <= res_stat_in;
      end
      if (e_load) e_ff <= e_in;
      if (fwd_load) begin
         fwd_ff  <= fwd_in;
         fcnt_ff <= FCW'(1);
      end else if (fwd_step) begin
         fwd_ff  <= fwd_rest;
         fcnt_ff <= fcnt_ff + FCW'(1);
      end

      // Start a scan or advance it
      if (scan_go) begin
         cnt_ff <= '0; chk_ff <= 1'b0;
         l_hit_ff <= 1'b0; l_free_ff <= 1'b0;
         c_hit_ff <= 1'b0; c_free_ff <= 1'b0;
         p_hit_ff <= 1'b0; p_idm_ff <= 1'b0; p_free_ff <= 1'b0;
         f_pm_ff <= 1'b0; f_wait_ff <= 1'b0; f_resp_ff <= 1'b0;
      end else if (scanning) begin
         if (cnt_ff < scan_lim) cnt_ff <= cnt_ff + CNTW'(1);
         chk_ff <= (cnt_ff < scan_lim);
         idx_ff <= cnt_ff;
      end

      // Examine the entry read in the previous cycle
      if (!scan_go && chk_ff) begin
         case (state_ff)
            S_LOC_SCAN: begin
               if (local_valid_ff[idx_ff[LAW-1:0]]) begin
                  if (l_rd == name_ff && !l_hit_ff) begin
                     l_hit_ff <= 1'b1; l_hidx_ff <= idx_ff[LAW-1:0];
                  end
               end else if (!l_free_ff) begin
                  l_free_ff <= 1'b1; l_fidx_ff <= idx_ff[LAW-1:0];
               end
            end
            S_CACHE_SCAN: begin
               if (cache_valid_ff[idx_ff[CAW-1:0]]) begin
                  if (c_rd[NB+31:32] == name_ff && !c_hit_ff) begin
                     c_hit_ff <= 1'b1; c_hidx_ff <= idx_ff[CAW-1:0];
                  end
               end else if (!c_free_ff) begin
                  c_free_ff <= 1'b1; c_fidx_ff <= idx_ff[CAW-1:0];
               end
               if (idx_ff == '0 || c_rd[31:0] < c_mstamp_ff) begin
                  c_midx_ff <= idx_ff[CAW-1:0]; c_mstamp_ff <= c_rd[31:0];
               end
            end
            S_PIT_SCAN: begin
               if (pit_valid_ff[idx_ff[PAW-1:0]]) begin
                  if (p_rd[NB+7:NB] == id_ff) begin
                     p_idm_ff <= 1'b1;
                     if (p_rd[NB-1:0] == name_ff && !p_hit_ff) begin
                        p_hit_ff <= 1'b1; p_hidx_ff <= idx_ff[PAW-1:0];
                     end
                  end
               end else if (!p_free_ff) begin
                  p_free_ff <= 1'b1; p_fidx_ff <= idx_ff[PAW-1:0];
               end
            end
            S_FACE_SCAN: begin
               if (idx_ff < CNTW'(fcount_cur)) begin
                  if (!f_pm_ff && f_rd[5:2] == {1'b0, port_ff}) begin
                     f_pm_ff <= 1'b1; f_pmidx_ff <= FCW'(idx_ff);
                  end
                  // On a noobject the first face on the arrival port counts as closed
                  if (cmd_ff != CMD_NOOBJECT || f_pm_ff || f_rd[5:2] != {1'b0, port_ff}) begin
                     if (f_rd[1:0] == FS_WAIT) f_wait_ff <= 1'b1;
                     if (f_rd[1:0] == FS_RESP && !f_resp_ff) begin
                        f_resp_ff <= 1'b1; f_rport_ff <= f_rd[5:2];
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule
